[hdl/bsfc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_pkg
// Shared types, codes and defaults for the blob shape filter and counter.
// ----------------------------------------------------------------------------
package bsfc_pkg;

	localparam int ID_SLOTS_DEF = 64;
	localparam int ID_W         = 16;
	localparam int LINE_W       = 12;
	localparam int AREA_CFG_W   = 24;
	localparam int SIDE_CFG_W   = 12;
	localparam int CFG_DW       = 24;
	localparam int CFG_IW       = 3;
	localparam int CNT_W        = 16;

	localparam logic [AREA_CFG_W-1:0] BLANK_AREA_DEF = 24'd80000;
	localparam logic [AREA_CFG_W-1:0] MIN_AREA_DEF   = 24'd100;
	localparam logic [AREA_CFG_W-1:0] MAX_AREA_DEF   = 24'd2000;
	localparam logic [SIDE_CFG_W-1:0] MIN_SIDE_DEF   = 12'd8;
	localparam logic [SIDE_CFG_W-1:0] MAX_SIDE_DEF   = 12'd60;
	localparam logic [SIDE_CFG_W-1:0] MAX_DIFF_DEF   = 12'd24;

	typedef enum logic [CFG_IW-1:0] {
		REG_BLANK_AREA = 3'd0,
		REG_MIN_AREA   = 3'd1,
		REG_MAX_AREA   = 3'd2,
		REG_MIN_SIDE   = 3'd3,
		REG_MAX_SIDE   = 3'd4,
		REG_MAX_DIFF   = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		RSN_COUNTED      = 4'd0,
		RSN_BLANK        = 4'd1,
		RSN_REPEAT       = 4'd2,
		RSN_ASPECT       = 4'd3,
		RSN_AREA_SMALL   = 4'd4,
		RSN_AREA_LARGE   = 4'd5,
		RSN_HEIGHT_SMALL = 4'd6,
		RSN_HEIGHT_LARGE = 4'd7,
		RSN_WIDTH_SMALL  = 4'd8,
		RSN_WIDTH_LARGE  = 4'd9,
		RSN_CLEARED      = 4'd10
	} reason_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_CLASS,
		ST_SCAN,
		ST_FINISH
	} state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage
`default_nettype wire

[hdl/blob_shape_filter_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// blob_shape_filter_counter
// Shape filter and new-object counter for finished blobs, with an id list.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A clear command, or a blob that is
// rejected on its shape or taken as blank, goes from the calc state through
// the class state to the finish state, where its result is loaded. A blob
// that passes the shape checks first scans the id list in memory, one entry
// per cycle, over the seen_count entries in use (at most ID_SLOTS), and stops
// early when its id turns up; the single read port of the id list sets that
// pace. The block takes a new item in the cycle after its result is loaded
// into the output register, even while that result still waits to be taken.
// The counter outputs show the totals after the step of the result on offer.
// The id list needs no clearing pass: only entries below the fill count are
// ever read, so a clear just resets that count.
// ----------------------------------------------------------------------------
module blob_shape_filter_counter #(
	parameter int ID_SLOTS = bsfc_pkg::ID_SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_we,
	input  wire logic [bsfc_pkg::CFG_IW-1:0]   cfg_index,
	input  wire logic [bsfc_pkg::CFG_DW-1:0]   cfg_data,
	// input channel
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          cmd,
	input  wire logic [bsfc_pkg::ID_W-1:0]     blob_id,
	input  wire logic [bsfc_pkg::LINE_W-1:0]   bottom_line,
	input  wire logic [bsfc_pkg::LINE_W-1:0]   top_line,
	input  wire logic [bsfc_pkg::LINE_W-1:0]   blob_width,
	// output channel
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               counted,
	output logic                               blank_seen,
	output logic [3:0]                         reason_code,
	output logic [bsfc_pkg::CNT_W-1:0]         object_total,
	output logic [bsfc_pkg::CNT_W-1:0]         reject_total,
	output logic [bsfc_pkg::CNT_W-1:0]         repeat_rejects,
	output logic [bsfc_pkg::CNT_W-1:0]         aspect_rejects,
	output logic [bsfc_pkg::CNT_W-1:0]         large_area_rejects,
	output logic [bsfc_pkg::CNT_W-1:0]         tall_rejects,
	output logic [bsfc_pkg::CNT_W-1:0]         wide_rejects,
	output logic                               table_full
);

	import bsfc_pkg::*;

	localparam int CW = $clog2(ID_SLOTS + 1);
	localparam int AW = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
	localparam logic [CW-1:0] SLOTS_C = CW'(ID_SLOTS);

	// configuration registers
	logic [AREA_CFG_W-1:0] blank_area_q, min_area_q, max_area_q;
	logic [SIDE_CFG_W-1:0] min_side_q, max_side_q, max_diff_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_area_q <= BLANK_AREA_DEF;
			min_area_q   <= MIN_AREA_DEF;
			max_area_q   <= MAX_AREA_DEF;
			min_side_q   <= MIN_SIDE_DEF;
			max_side_q   <= MAX_SIDE_DEF;
			max_diff_q   <= MAX_DIFF_DEF;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLANK_AREA: blank_area_q <= cfg_data;
				REG_MIN_AREA:   min_area_q   <= cfg_data;
				REG_MAX_AREA:   max_area_q   <= cfg_data;
				REG_MIN_SIDE:   min_side_q   <= cfg_data[SIDE_CFG_W-1:0];
				REG_MAX_SIDE:   max_side_q   <= cfg_data[SIDE_CFG_W-1:0];
				REG_MAX_DIFF:   max_diff_q   <= cfg_data[SIDE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// control
	state_t state_q, state_nxt;
	logic   in_fire, fin_fire, rd_en, hit, issue;

	// captured item
	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [LINE_W-1:0] bottom_q, top_q, width_q;

	// arithmetic stage
	logic signed [12:0] h_c, h_s1;
	logic signed [25:0] area_c, area_s1;
	logic signed [13:0] diff_c;
	logic        [12:0] adiff_c, adiff_s1;

	// classification
	reason_t reason_c, reason_q, final_reason;
	logic    known_q;

	// id scan
	logic [CW-1:0]   scan_idx_q;
	logic            rd_pend_q;
	logic [ID_W-1:0] rd_data;
	logic [CW-1:0]   seen_count_q;
	logic            ram_we;

	// counters and flags
	logic [CNT_W-1:0] obj_q, tot_q, rep_q, asp_q, lrg_q, tall_q, wide_q;
	logic             blank_q, out_valid_q, counted_q, full_q;
	reason_t          out_reason_q;

	assign in_fire = in_valid && in_ready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q    <= cmd;
			id_q     <= blob_id;
			bottom_q <= bottom_line;
			top_q    <= top_line;
			width_q  <= blob_width;
		end
	end

	// height, area and side difference
	always_comb begin
		h_c     = $signed({1'b0, bottom_q}) - $signed({1'b0, top_q});
		area_c  = 26'(h_c) * 26'($signed({1'b0, width_q}));
		diff_c  = $signed({2'b00, width_q}) - $signed({h_c[12], h_c});
		adiff_c = diff_c[13] ? 13'(-diff_c) : diff_c[12:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			h_s1     <= h_c;
			area_s1  <= area_c;
			adiff_s1 <= adiff_c;
		end
	end

	// checks in order: blank, width, height, area, side difference
	always_comb begin
		logic signed [25:0] blank_lim, amin, amax;
		logic signed [12:0] smin, smax;
		blank_lim = $signed({2'b00, blank_area_q});
		amin      = $signed({2'b00, min_area_q});
		amax      = $signed({2'b00, max_area_q});
		smin      = $signed({1'b0, min_side_q});
		smax      = $signed({1'b0, max_side_q});
		if (cmd_q) begin
			reason_c = RSN_CLEARED;
		end else if (area_s1 > blank_lim) begin
			reason_c = RSN_BLANK;
		end else if (!(width_q > min_side_q && width_q < max_side_q)) begin
			reason_c = (width_q > max_side_q) ? RSN_WIDTH_LARGE : RSN_WIDTH_SMALL;
		end else if (!(h_s1 > smin && h_s1 < smax)) begin
			reason_c = (h_s1 > smax) ? RSN_HEIGHT_LARGE : RSN_HEIGHT_SMALL;
		end else if (!(area_s1 > amin && area_s1 < amax)) begin
			reason_c = (area_s1 > amax) ? RSN_AREA_LARGE : RSN_AREA_SMALL;
		end else if (!(adiff_s1 < {1'b0, max_diff_q})) begin
			reason_c = RSN_ASPECT;
		end else begin
			reason_c = RSN_COUNTED;
		end
	end

	assign hit   = rd_pend_q && (rd_data == id_q);
	assign issue = scan_idx_q < seen_count_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_CALC;
			ST_CALC:   state_nxt = ST_CLASS;
			ST_CLASS:  state_nxt = (reason_c == RSN_COUNTED) ? ST_SCAN : ST_FINISH;
			ST_SCAN:   if (hit || !issue) state_nxt = ST_FINISH;
			ST_FINISH: if (!out_valid_q || out_ready) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		fin_fire = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SCAN:   rd_en    = !hit && issue;
			ST_FINISH: fin_fire = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// scan of the id list, one entry per cycle, compare in the cycle after the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			rd_pend_q  <= 1'b0;
			known_q    <= 1'b0;
			reason_q   <= RSN_COUNTED;
		end else begin
			case (state_q)
				ST_CLASS: begin
					reason_q   <= reason_c;
					scan_idx_q <= '0;
					rd_pend_q  <= 1'b0;
					known_q    <= 1'b0;
				end
				ST_SCAN: begin
					rd_pend_q <= rd_en;
					if (rd_en) scan_idx_q <= scan_idx_q + 1'b1;
					if (hit) known_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	bsfc_id_ram #(
		.DEPTH (ID_SLOTS),
		.AW    (AW),
		.DW    (ID_W)
	) u_id_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (seen_count_q[AW-1:0]),
		.wdata (id_q),
		.re    (rd_en),
		.raddr (scan_idx_q[AW-1:0]),
		.rdata (rd_data)
	);

	// id 0 is never a repeat
	assign final_reason = (reason_q == RSN_COUNTED && id_q != '0 && known_q) ?
		RSN_REPEAT : reason_q;
	assign ram_we = fin_fire && final_reason == RSN_COUNTED && !known_q &&
		seen_count_q < SLOTS_C;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_q        <= '0;
			tot_q        <= '0;
			rep_q        <= '0;
			asp_q        <= '0;
			lrg_q        <= '0;
			tall_q       <= '0;
			wide_q       <= '0;
			blank_q      <= 1'b0;
			seen_count_q <= '0;
			out_valid_q  <= 1'b0;
			counted_q    <= 1'b0;
			full_q       <= 1'b0;
			out_reason_q <= RSN_COUNTED;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (fin_fire) begin
				out_valid_q  <= 1'b1;
				out_reason_q <= final_reason;
				counted_q    <= (final_reason == RSN_COUNTED);
				full_q       <= (final_reason == RSN_COUNTED) && !known_q &&
					seen_count_q == SLOTS_C;
				case (final_reason)
					RSN_CLEARED: begin
						obj_q        <= '0;
						tot_q        <= '0;
						rep_q        <= '0;
						asp_q        <= '0;
						lrg_q        <= '0;
						tall_q       <= '0;
						wide_q       <= '0;
						blank_q      <= 1'b0;
						seen_count_q <= '0;
					end
					RSN_BLANK: blank_q <= 1'b1;
					RSN_WIDTH_LARGE: begin
						wide_q <= sat_inc(wide_q);
						tot_q  <= sat_inc(tot_q);
					end
					RSN_HEIGHT_LARGE: begin
						tall_q <= sat_inc(tall_q);
						tot_q  <= sat_inc(tot_q);
					end
					RSN_AREA_LARGE: begin
						lrg_q <= sat_inc(lrg_q);
						tot_q <= sat_inc(tot_q);
					end
					RSN_ASPECT: begin
						asp_q <= sat_inc(asp_q);
						tot_q <= sat_inc(tot_q);
					end
					RSN_REPEAT: begin
						rep_q <= sat_inc(rep_q);
						tot_q <= sat_inc(tot_q);
					end
					RSN_COUNTED: begin
						obj_q <= sat_inc(obj_q);
						if (ram_we) seen_count_q <= seen_count_q + 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign counted            = counted_q;
	assign blank_seen         = blank_q;
	assign reason_code        = out_reason_q;
	assign object_total       = obj_q;
	assign reject_total       = tot_q;
	assign repeat_rejects     = rep_q;
	assign aspect_rejects     = asp_q;
	assign large_area_rejects = lrg_q;
	assign tall_rejects       = tall_q;
	assign wide_rejects       = wide_q;
	assign table_full         = full_q;

endmodule
`default_nettype wire

[hdl/bsfc_id_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsfc_id_ram
// Id list storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bsfc_id_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 16
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
